@@ sv/mac_byte_accounting_table_top_assert.svh @@
// assertion helpers for the accounting table top level
`ifndef MAC_BYTE_ACCOUNTING_TABLE_TOP_ASSERT_SVH
`define MAC_BYTE_ACCOUNTING_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MBAT_ASSERT_NOW(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MBAT_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ sv/mbat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mbat_pkg;

	localparam int MAC_W       = 48;
	localparam int LEN_W       = 16;
	localparam int PREFIX_W    = 24;
	localparam int SLOT_OUT_W  = 9;
	localparam int FILL_OUT_W  = 10;
	localparam int TOT_OUT_W   = 64;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 160;

	localparam logic [PREFIX_W-1:0] PREFIX_RESET = {8'h00, 8'h0b, 8'hab};

	// control part of the search token that walks the cell row
	typedef struct packed {
		logic valid;
		logic src_pre;
		logic dst_pre;
		logic src_found;
		logic dst_found;
	} mbat_ctl_t;

endpackage
`default_nettype wire

@@ sv/mbat_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mbat_cell #(
	parameter int TABLE_DEPTH  = 512,
	parameter int COUNTER_BITS = 64,
	parameter int INDEX        = 0,
	parameter int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire mbat_pkg::mbat_ctl_t      ctl_in,
	input  wire [mbat_pkg::MAC_W-1:0]     src_in,
	input  wire [mbat_pkg::MAC_W-1:0]     dst_in,
	input  wire [mbat_pkg::LEN_W-1:0]     len_in,
	input  wire [SW-1:0]                  src_slot_in,
	input  wire [COUNTER_BITS-1:0]        src_tot_in,
	input  wire [SW-1:0]                  dst_slot_in,
	input  wire [COUNTER_BITS-1:0]        dst_tot_in,
	input  wire [CW-1:0]                  cnt_in,
	output mbat_pkg::mbat_ctl_t           ctl_out,
	output logic [mbat_pkg::MAC_W-1:0]    src_out,
	output logic [mbat_pkg::MAC_W-1:0]    dst_out,
	output logic [mbat_pkg::LEN_W-1:0]    len_out,
	output logic [SW-1:0]                 src_slot_out,
	output logic [COUNTER_BITS-1:0]       src_tot_out,
	output logic [SW-1:0]                 dst_slot_out,
	output logic [COUNTER_BITS-1:0]       dst_tot_out,
	output logic [CW-1:0]                 cnt_out
);
	import mbat_pkg::*;

	logic                    vld_q;
	logic [MAC_W-1:0]        mac_q;
	logic [COUNTER_BITS-1:0] dl_q;
	logic [COUNTER_BITS-1:0] ul_q;

	mbat_ctl_t               ctl_q;
	logic [MAC_W-1:0]        src_q;
	logic [MAC_W-1:0]        dst_q;
	logic [LEN_W-1:0]        len_q;
	logic [SW-1:0]           src_slot_q;
	logic [COUNTER_BITS-1:0] src_tot_q;
	logic [SW-1:0]           dst_slot_q;
	logic [COUNTER_BITS-1:0] dst_tot_q;
	logic [CW-1:0]           cnt_q;

	logic                    s_match, d_match, ins_src, ins_dst, vld_nx;
	logic [COUNTER_BITS-1:0] len_ext, dl_nx, ul_nx;
	logic [MAC_W-1:0]        mac_nx;

	always_comb begin
		len_ext = COUNTER_BITS'(len_in);
		s_match = ctl_in.valid && vld_q && !ctl_in.src_found && (mac_q == src_in);
		d_match = ctl_in.valid && vld_q && !ctl_in.dst_found && (mac_q == dst_in);
		// first free cell takes the source if it has the vendor prefix, the destination takes it too when
		// it is the same address, otherwise it moves on to the next free cell
		ins_src = ctl_in.valid && !vld_q && !ctl_in.src_found && ctl_in.src_pre;
		ins_dst = ctl_in.valid && !vld_q && !ctl_in.dst_found && ctl_in.dst_pre &&
			(!ins_src || (dst_in == src_in));
		dl_nx = s_match ? dl_q + len_ext : ins_src ? len_ext : ins_dst ? '0 : dl_q;
		ul_nx = d_match ? ul_q + len_ext : ins_dst ? len_ext : ins_src ? '0 : ul_q;
		mac_nx = ins_src ? src_in : ins_dst ? dst_in : mac_q;
		vld_nx = vld_q || ins_src || ins_dst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl_in.valid) begin
			vld_q <= vld_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			mac_q <= mac_nx;
			dl_q  <= dl_nx;
			ul_q  <= ul_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid     <= ctl_in.valid;
			ctl_q.src_pre   <= ctl_in.src_pre;
			ctl_q.dst_pre   <= ctl_in.dst_pre;
			ctl_q.src_found <= ctl_in.src_found || s_match || ins_src;
			ctl_q.dst_found <= ctl_in.dst_found || d_match || ins_dst;
		end
	end

	always_ff @(posedge clk) begin
		src_q      <= src_in;
		dst_q      <= dst_in;
		len_q      <= len_in;
		src_slot_q <= (s_match || ins_src) ? SW'(INDEX) : src_slot_in;
		src_tot_q  <= (s_match || ins_src) ? dl_nx : src_tot_in;
		dst_slot_q <= (d_match || ins_dst) ? SW'(INDEX) : dst_slot_in;
		dst_tot_q  <= (d_match || ins_dst) ? ul_nx : dst_tot_in;
		cnt_q      <= vld_nx ? cnt_in + CW'(1) : cnt_in;
	end

	assign ctl_out      = ctl_q;
	assign src_out      = src_q;
	assign dst_out      = dst_q;
	assign len_out      = len_q;
	assign src_slot_out = src_slot_q;
	assign src_tot_out  = src_tot_q;
	assign dst_slot_out = dst_slot_q;
	assign dst_tot_out  = dst_tot_q;
	assign cnt_out      = cnt_q;

endmodule
`default_nettype wire

@@ sv/mac_byte_accounting_table_top.sv @@
// channel   dir  width  contents
// s_*       in   112    one frame: source mac, destination mac, length
// m_*       out  160    one result per frame: hits, slots, totals, fill, full
// cfg_*     in   24     vendor prefix register
//
// a search token walks the cell row one cell per cycle, from accept to result;
// the row holds one frame at a time; the next frame can be taken once the result
// has left the row, provided a result slot is free
// two result slots let a new frame start while an earlier result is unread
// reset empties the table at once (per-cell valid flags) and restores the prefix
`timescale 1ns / 1ps
`default_nettype none
module mac_byte_accounting_table_top #(
	parameter int TABLE_DEPTH  = 512,
	parameter int COUNTER_BITS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// source_mac, dest_mac, frame_length
	input  wire [mbat_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// source_hit, source_slot, source_download_total, dest_hit, dest_slot,
	// dest_upload_total, fill_count, table_full, zero pad
	output logic [mbat_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire                                cfg_we,
	input  wire [mbat_pkg::PREFIX_W-1:0]       cfg_wdata
);
	import mbat_pkg::*;
`include "mac_byte_accounting_table_top_assert.svh"

	localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [PREFIX_W-1:0] prefix_q;
	logic                busy_q;
	logic [1:0]          fifo_cnt_q;
	logic [OUT_TDATA_W-1:0] ent0_q, ent1_q;

	mbat_ctl_t               t_ctl      [0:TABLE_DEPTH];
	logic [MAC_W-1:0]        t_src      [0:TABLE_DEPTH];
	logic [MAC_W-1:0]        t_dst      [0:TABLE_DEPTH];
	logic [LEN_W-1:0]        t_len      [0:TABLE_DEPTH];
	logic [SW-1:0]           t_src_slot [0:TABLE_DEPTH];
	logic [COUNTER_BITS-1:0] t_src_tot  [0:TABLE_DEPTH];
	logic [SW-1:0]           t_dst_slot [0:TABLE_DEPTH];
	logic [COUNTER_BITS-1:0] t_dst_tot  [0:TABLE_DEPTH];
	logic [CW-1:0]           t_cnt      [0:TABLE_DEPTH];

	logic                   accept, push, pop, last_valid;
	logic [OUT_TDATA_W-1:0] result;
	logic [CW-1:0]          fill;

	assign accept = s_tvalid && s_tready;
	assign s_tready = !busy_q && (fifo_cnt_q != 2'd2);

	always_comb begin
		t_ctl[0].valid     = accept;
		t_ctl[0].src_pre   = s_tdata[47:24] == prefix_q;
		t_ctl[0].dst_pre   = s_tdata[95:72] == prefix_q;
		t_ctl[0].src_found = 1'b0;
		t_ctl[0].dst_found = 1'b0;
		t_src[0]      = s_tdata[47:0];
		t_dst[0]      = s_tdata[95:48];
		t_len[0]      = s_tdata[111:96];
		t_src_slot[0] = '0;
		t_src_tot[0]  = '0;
		t_dst_slot[0] = '0;
		t_dst_tot[0]  = '0;
		t_cnt[0]      = '0;
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		mbat_cell #(
			.TABLE_DEPTH (TABLE_DEPTH),
			.COUNTER_BITS(COUNTER_BITS),
			.INDEX       (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl_in      (t_ctl[i]),
			.src_in      (t_src[i]),
			.dst_in      (t_dst[i]),
			.len_in      (t_len[i]),
			.src_slot_in (t_src_slot[i]),
			.src_tot_in  (t_src_tot[i]),
			.dst_slot_in (t_dst_slot[i]),
			.dst_tot_in  (t_dst_tot[i]),
			.cnt_in      (t_cnt[i]),
			.ctl_out     (t_ctl[i+1]),
			.src_out     (t_src[i+1]),
			.dst_out     (t_dst[i+1]),
			.len_out     (t_len[i+1]),
			.src_slot_out(t_src_slot[i+1]),
			.src_tot_out (t_src_tot[i+1]),
			.dst_slot_out(t_dst_slot[i+1]),
			.dst_tot_out (t_dst_tot[i+1]),
			.cnt_out     (t_cnt[i+1])
		);
	end

	assign last_valid = t_ctl[TABLE_DEPTH].valid;
	assign fill       = t_cnt[TABLE_DEPTH];
	assign push       = last_valid;
	assign pop        = m_tvalid && m_tready;

	always_comb begin
		result = {1'b0,
			fill == CW'(TABLE_DEPTH),
			FILL_OUT_W'(fill),
			TOT_OUT_W'(t_dst_tot[TABLE_DEPTH]),
			SLOT_OUT_W'(t_dst_slot[TABLE_DEPTH]),
			t_ctl[TABLE_DEPTH].dst_found,
			TOT_OUT_W'(t_src_tot[TABLE_DEPTH]),
			SLOT_OUT_W'(t_src_slot[TABLE_DEPTH]),
			t_ctl[TABLE_DEPTH].src_found};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q   <= PREFIX_RESET;
			busy_q     <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				prefix_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last_valid) begin
				busy_q <= 1'b0;
			end
			fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
		end
	end

	// two-entry result queue, head in ent0
	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= ent1_q;
		end
		if (push) begin
			if (fifo_cnt_q == 2'(pop)) begin
				ent0_q <= result;
			end else begin
				ent1_q <= result;
			end
		end
	end

	assign m_tvalid = fifo_cnt_q != 2'd0;
	assign m_tdata  = ent0_q;

	`MBAT_ASSERT_NOW(a_no_overflow, clk, arst_n, last_valid, (fifo_cnt_q != 2'd2) || pop)
	`MBAT_ASSERT_NOW(a_token_owned, clk, arst_n, last_valid, busy_q)
	`MBAT_ASSERT_NOW(a_fill_bound, clk, arst_n, last_valid, fill <= CW'(TABLE_DEPTH))
	`MBAT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy_q || m_tvalid)

endmodule
`default_nettype wire
